[rtl/amf3_number_encoder_top_macros.svh]
// Assertion macros for the encoder's RTL; amf3ne_back is the file that includes them.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef AMF3_NUMBER_ENCODER_TOP_MACROS_SVH
`define AMF3_NUMBER_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define AMF3NE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AMF3NE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AMF3NE_ASSERT_IMPL(lbl, ante, cons, msg)

`define AMF3NE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/amf3ne_pkg.sv]
package amf3ne_pkg;

  localparam logic       CMD_INT  = 1'b0;
  localparam logic       CMD_DBL  = 1'b1;

  localparam logic [7:0] MARK_INT = 8'h04;
  localparam logic [7:0] MARK_DBL = 8'h05;

  localparam logic [10:0] EXP_BIAS = 11'd1023;

  // Bytes that follow the marker of a double.
  localparam logic [3:0] DBL_NBYTES = 4'd8;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic        is_int;
    logic [3:0]  nbytes;   // bytes after the marker
    logic [63:0] data;     // U29 value in the low bits, or double bits
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Length of the U29 code for a 29-bit value.
  function automatic logic [3:0] u29_len(input logic [28:0] v);
    logic [3:0] n;
    if (v < 29'h80) begin
      n = 4'd1;
    end else if (v < 29'h4000) begin
      n = 4'd2;
    end else if (v < 29'h20_0000) begin
      n = 4'd3;
    end else begin
      n = 4'd4;
    end
    return n;
  endfunction

  // Byte k (1 = first) of an n-byte U29 code.
  function automatic logic [7:0] u29_byte(input logic [28:0] v, input logic [3:0] n,
                                          input logic [3:0] k);
    logic [7:0] b;
    b = {1'b0, v[6:0]};
    unique case (n)
      4'd2: begin
        unique case (k)
          4'd1:    b = {1'b1, v[13:7]};
          default: b = {1'b0, v[6:0]};
        endcase
      end
      4'd3: begin
        unique case (k)
          4'd1:    b = {1'b1, v[20:14]};
          4'd2:    b = {1'b1, v[13:7]};
          default: b = {1'b0, v[6:0]};
        endcase
      end
      4'd4: begin
        unique case (k)
          4'd1:    b = {1'b1, v[28:22]};
          4'd2:    b = {1'b1, v[21:15]};
          4'd3:    b = {1'b1, v[14:8]};
          default: b = v[7:0];
        endcase
      end
      default: b = {1'b0, v[6:0]};
    endcase
    return b;
  endfunction

endpackage

[rtl/amf3ne_ifs.sv]
interface amf3ne_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [63:0] int_value;
  logic        [63:0] double_bits;

  modport source (output valid, cmd, int_value, double_bits, input ready);
  modport sink   (input valid, cmd, int_value, double_bits, output ready);
endinterface

interface amf3ne_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

[rtl/amf3ne_fifo.sv]
module amf3ne_fifo #(
  parameter int DEPTH = amf3ne_pkg::FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  amf3ne_pkg::entry_t     wr_entry,
  input  logic                   pop,
  output amf3ne_pkg::entry_t     head,
  output amf3ne_pkg::fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  amf3ne_pkg::entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);

endmodule

[rtl/amf3ne_front.sv]
module amf3ne_front (
  input  logic                   clk,
  input  logic                   rst_n,
  amf3ne_in_if.sink              in_ch,
  input  amf3ne_pkg::fifo_stat_t q_stat,
  output logic                   q_push,
  output amf3ne_pkg::entry_t     q_entry
);

  logic adv;

  // Stage 1: classify, take magnitude
  logic        s1_v_r, s1_cmd_r, s1_fits_r, s1_sign_r;
  logic [63:0] s1_data_r;
  // Stage 2: leading-one position
  logic        s2_v_r, s2_cmd_r, s2_fits_r, s2_sign_r;
  logic [63:0] s2_data_r;
  logic [5:0]  s2_p_r;
  // Stage 3: normalized magnitude
  logic        s3_v_r, s3_cmd_r, s3_fits_r, s3_sign_r;
  logic [63:0] s3_data_r, s3_norm_r;
  logic [5:0]  s3_p_r;

  logic [63:0] iv_raw, iv_mag;
  logic        iv_sign, iv_fits;
  logic [2:0]  hi_byte, hi_bit;
  logic [7:0]  sel_byte;
  logic [5:0]  p_nxt;

  logic        rnd_up, carry;
  logic [53:0] mant;
  logic [51:0] frac;
  logic [10:0] expo;
  logic [63:0] dbl_bits;

  // Whole pipe holds while the last stage cannot enter the queue.
  assign adv         = !(s3_v_r && q_stat.full);
  assign in_ch.ready = adv;

  assign iv_raw  = in_ch.int_value;
  assign iv_sign = iv_raw[63];
  assign iv_fits = (&iv_raw[63:28]) || !(|iv_raw[63:28]);
  assign iv_mag  = iv_sign ? (64'd0 - iv_raw) : iv_raw;

  always_comb begin
    hi_byte = '0;
    for (int i = 0; i < 8; i++) begin
      if (|s1_data_r[8*i +: 8]) begin
        hi_byte = 3'(i);
      end
    end
    sel_byte = s1_data_r[{hi_byte, 3'b000} +: 8];
    hi_bit = '0;
    for (int j = 0; j < 8; j++) begin
      if (sel_byte[j]) begin
        hi_bit = 3'(j);
      end
    end
    p_nxt = {hi_byte, hi_bit};
  end

  always_comb begin
    rnd_up   = s3_norm_r[10] && ((|s3_norm_r[9:0]) || s3_norm_r[11]);
    mant     = {1'b0, s3_norm_r[63:11]} + 54'(rnd_up);
    carry    = mant[53];
    frac     = carry ? mant[52:1] : mant[51:0];
    expo     = 11'(s3_p_r) + amf3ne_pkg::EXP_BIAS + 11'(carry);
    dbl_bits = {s3_sign_r, expo, frac};
  end

  always_comb begin
    if (s3_cmd_r == amf3ne_pkg::CMD_DBL) begin
      q_entry.is_int = 1'b0;
      q_entry.nbytes = amf3ne_pkg::DBL_NBYTES;
      q_entry.data   = s3_data_r;
    end else if (s3_fits_r) begin
      q_entry.is_int = 1'b1;
      q_entry.nbytes = amf3ne_pkg::u29_len(s3_data_r[28:0]);
      q_entry.data   = {35'd0, s3_data_r[28:0]};
    end else begin
      q_entry.is_int = 1'b0;
      q_entry.nbytes = amf3ne_pkg::DBL_NBYTES;
      q_entry.data   = dbl_bits;
    end
  end

  assign q_push = s3_v_r && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_fits_r <= iv_fits;
      s1_sign_r <= iv_sign;
      if (in_ch.cmd == amf3ne_pkg::CMD_DBL) begin
        s1_data_r <= in_ch.double_bits;
      end else if (iv_fits) begin
        s1_data_r <= iv_raw;
      end else begin
        s1_data_r <= iv_mag;
      end

      s2_cmd_r  <= s1_cmd_r;
      s2_fits_r <= s1_fits_r;
      s2_sign_r <= s1_sign_r;
      s2_data_r <= s1_data_r;
      s2_p_r    <= p_nxt;

      s3_cmd_r  <= s2_cmd_r;
      s3_fits_r <= s2_fits_r;
      s3_sign_r <= s2_sign_r;
      s3_data_r <= s2_data_r;
      s3_norm_r <= s2_data_r << (6'd63 - s2_p_r);
      s3_p_r    <= s2_p_r;
    end
  end

endmodule

[rtl/amf3ne_back.sv]
`include "amf3_number_encoder_top_macros.svh"

module amf3ne_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  amf3ne_pkg::entry_t     head,
  input  amf3ne_pkg::fifo_stat_t q_stat,
  output logic                   q_pop,
  amf3ne_out_if.source           out_ch
);

  amf3ne_pkg::entry_t cur_r, cur;
  logic       busy_r;
  logic [3:0] pos_r, pos;
  logic       out_valid_r, out_last_r;
  logic [7:0] out_byte_r;

  logic       have, ld, go, is_last;
  logic [7:0] byte_nxt;
  logic [63:0] dbl_shift;

  assign cur  = busy_r ? cur_r : head;
  assign pos  = busy_r ? pos_r : 4'd0;
  assign have = busy_r || !q_stat.empty;
  assign ld   = !out_valid_r || out_ch.ready;
  assign go   = ld && have;
  assign q_pop = go && !busy_r;

  assign is_last   = (pos == cur.nbytes);
  assign dbl_shift = cur.data >> {(4'd8 - pos), 3'b000};

  always_comb begin
    if (pos == 4'd0) begin
      byte_nxt = cur.is_int ? amf3ne_pkg::MARK_INT : amf3ne_pkg::MARK_DBL;
    end else if (cur.is_int) begin
      byte_nxt = amf3ne_pkg::u29_byte(cur.data[28:0], cur.nbytes, pos);
    end else begin
      byte_nxt = dbl_shift[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (ld) begin
        out_valid_r <= have;
      end
      if (go) begin
        busy_r <= !is_last;
        pos_r  <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte_r <= byte_nxt;
      out_last_r <= is_last;
    end
    if (q_pop) begin
      cur_r <= head;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  `AMF3NE_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
  `AMF3NE_ASSERT_IMPL(a_pos_range, busy_r, (pos_r != 4'd0) && (pos_r <= cur_r.nbytes), "byte position out of range")
  `AMF3NE_ASSERT_NEXT(a_marker_first, go && (pos == 4'd0), (out_byte_r == amf3ne_pkg::MARK_INT) || (out_byte_r == amf3ne_pkg::MARK_DBL), "first beat is not a marker")

endmodule

[rtl/amf3_number_encoder_top.sv]
// AMF3 number encoder. Each input beat carries one number (cmd 0: signed 64-bit
// integer, cmd 1: raw binary64 bits); the output channel returns its AMF3 encoding
// one byte per beat, marker first, with last set on the final byte. Integers in
// the signed 29-bit range give marker 0x04 and a 1 to 4 byte U29 code; other
// integers are rounded to nearest even into a double, and doubles give marker
// 0x05 and eight big-endian bytes, passed through bit for bit. Rate: the byte
// serializer emits one beat per cycle while the output is ready, and a number
// gives 1 + code length beats: 2 to 5 for a small integer, 9 for a double. The
// front pipeline accepts one number per cycle unless its last stage is held by
// a full queue; its stages are classify, leading-one search, normalize and
// round, and FIFO_DEPTH numbers can wait in the queue. No clearing after reset.
module amf3_number_encoder_top #(
  parameter int FIFO_DEPTH = amf3ne_pkg::FIFO_DEPTH
) (
  input logic          clk,
  input logic          rst_n,
  amf3ne_in_if.sink    in_ch,
  amf3ne_out_if.source out_ch
);

  amf3ne_pkg::entry_t     q_wr_entry;
  amf3ne_pkg::entry_t     q_head;
  amf3ne_pkg::fifo_stat_t q_stat;
  logic                   q_push;
  logic                   q_pop;

  // Front: accept, classify, convert wide integers to double bits.
  amf3ne_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_wr_entry)
  );

  // Queue: decouple number rate from byte rate.
  amf3ne_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Back: serialize marker and payload bytes into the output register.
  amf3ne_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
